// File: rtl/linear_message_queue_defines.svh
// Assertion macros for the linear message queue.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef LINEAR_MESSAGE_QUEUE_DEFINES_SVH
`define LINEAR_MESSAGE_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that is masked while reset is asserted.
`define LMQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that holds during reset as well.
`define LMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LMQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define LMQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/lmq_pkg.sv
// Shared constants and types for the linear message queue.
// No dependencies; used by lmq_core and linear_message_queue.
package lmq_pkg;

	localparam int AREA_BYTES = 4096;
	localparam int HEADER_BYTES = 4;

	localparam int PW = $clog2(AREA_BYTES + 1);
	localparam int AW = $clog2(AREA_BYTES);
	localparam int HDR_W = $clog2(HEADER_BYTES);
	localparam int LEN_W = 13;
	localparam int HL_W = 16;
	localparam int SUM_W = ((PW > HL_W) ? PW : HL_W) + 1;

	typedef enum logic [2:0] {
		KIND_WRITE_START = 3'd0,
		KIND_WRITE_BYTE  = 3'd1,
		KIND_READ_START  = 3'd2,
		KIND_READ_BYTE   = 3'd3,
		KIND_FLUSH       = 3'd4,
		KIND_REORG       = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_MSG    = 3'd1,
		ST_TOO_SMALL = 3'd2,
		ST_FULL      = 3'd3,
		ST_ERROR     = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [15:0]      msg_type;
		logic [LEN_W-1:0] msg_length;
		logic [LEN_W-1:0] capacity;
		logic [7:0]       data_byte;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [15:0]      out_type;
		logic [LEN_W-1:0] out_length;
		logic [7:0]       out_byte;
		logic             last_byte;
		logic [31:0]      written_count;
		logic [31:0]      read_count;
	} result_t;

endpackage

// File: rtl/lmq_core.sv
// Sequencer, pointers and byte store of the linear message queue.
// Depends on lmq_pkg for sizes, codes and the item and result structs.
module lmq_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lmq_pkg::item_t    item,
	input  logic              auto_flush,
	output logic              idle,
	output logic              done,
	output lmq_pkg::result_t  result
);

	typedef enum logic [3:0] {
		S_IDLE, S_WS_HDR, S_RS0, S_RS1, S_RS2, S_RS3, S_RS4,
		S_RB0, S_RB1, S_REORG, S_DONE
	} state_t;

	state_t state_q;

	logic [7:0] mem [lmq_pkg::AREA_BYTES];
	logic [7:0] rdata_q;

	logic [lmq_pkg::PW-1:0]    wp_q, pwp_q, rp_q, base_q, end_q, src_q, addr_s1;
	logic [lmq_pkg::LEN_W-1:0] wbl_q, rbl_q;
	logic [31:0]               mw_q, mr_q;
	logic                      v_s1;
	logic [lmq_pkg::HDR_W-1:0] hdr_q;
	logic [7:0]                lo_q, tlo_q;
	logic [lmq_pkg::HL_W-1:0]  hl_q;
	lmq_pkg::item_t            it_q;

	lmq_pkg::status_t          st_q;
	logic [15:0]               otype_q;
	logic [lmq_pkg::LEN_W-1:0] olen_q;
	logic [7:0]                obyte_q;
	logic                      last_q, chk_q;

	logic                      we, re;
	logic [lmq_pkg::PW-1:0]    waddr_p, raddr_p;
	logic [7:0]                wdata;
	logic [lmq_pkg::HL_W-1:0]  hl_c;
	logic [lmq_pkg::SUM_W-1:0] ws_need, rs_hdr_end, rs_msg_end;

	assign hl_c = {rdata_q, lo_q};
	assign ws_need = lmq_pkg::SUM_W'(wp_q) + lmq_pkg::SUM_W'(lmq_pkg::HEADER_BYTES)
		+ lmq_pkg::SUM_W'(item.msg_length);
	assign rs_hdr_end = lmq_pkg::SUM_W'(rp_q) + lmq_pkg::SUM_W'(lmq_pkg::HEADER_BYTES);
	assign rs_msg_end = rs_hdr_end + lmq_pkg::SUM_W'(hl_c);

	// Store port selection for the current step.
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr_p = '0;
		raddr_p = '0;
		wdata = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start && item.kind == lmq_pkg::KIND_WRITE_BYTE && wbl_q != '0) begin
					we = 1'b1;
					waddr_p = pwp_q;
					wdata = item.data_byte;
				end
			end
			S_WS_HDR: begin
				we = 1'b1;
				waddr_p = wp_q + lmq_pkg::PW'(hdr_q);
				if (hdr_q == lmq_pkg::HDR_W'(0)) wdata = it_q.msg_type[7:0];
				else if (hdr_q == lmq_pkg::HDR_W'(1)) wdata = it_q.msg_type[15:8];
				else if (hdr_q == lmq_pkg::HDR_W'(2)) wdata = it_q.msg_length[7:0];
				else if (hdr_q == lmq_pkg::HDR_W'(3)) wdata = 8'(it_q.msg_length >> 8);
				else wdata = '0;
			end
			S_RS0: begin
				re = 1'b1;
				raddr_p = rp_q + lmq_pkg::PW'(2);
			end
			S_RS1: begin
				re = 1'b1;
				raddr_p = rp_q + lmq_pkg::PW'(3);
			end
			S_RS2: begin
				re = 1'b1;
				raddr_p = rp_q;
			end
			S_RS3: begin
				re = 1'b1;
				raddr_p = rp_q + lmq_pkg::PW'(1);
			end
			S_RB0: begin
				re = 1'b1;
				raddr_p = rp_q;
			end
			S_REORG: begin
				re = (src_q < end_q);
				raddr_p = src_q;
				we = v_s1;
				waddr_p = addr_s1 - base_q;
				wdata = rdata_q;
			end
			default: begin
			end
		endcase
	end

	// Byte store with registered read data.
	always_ff @(posedge clk) begin
		if (we) mem[waddr_p[lmq_pkg::AW-1:0]] <= wdata;
		if (re) rdata_q <= mem[raddr_p[lmq_pkg::AW-1:0]];
	end

	// Sequencer, pointers and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wp_q <= '0;
			pwp_q <= '0;
			rp_q <= '0;
			wbl_q <= '0;
			rbl_q <= '0;
			mw_q <= '0;
			mr_q <= '0;
			v_s1 <= 1'b0;
			chk_q <= 1'b0;
			base_q <= '0;
			end_q <= '0;
			src_q <= '0;
			addr_s1 <= '0;
			hdr_q <= '0;
			lo_q <= '0;
			tlo_q <= '0;
			hl_q <= '0;
			it_q <= '0;
			st_q <= lmq_pkg::ST_OK;
			otype_q <= '0;
			olen_q <= '0;
			obyte_q <= '0;
			last_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						it_q <= item;
						st_q <= lmq_pkg::ST_OK;
						otype_q <= '0;
						olen_q <= '0;
						obyte_q <= '0;
						last_q <= 1'b0;
						chk_q <= 1'b0;
						state_q <= S_DONE;
						case (item.kind)
							lmq_pkg::KIND_WRITE_START: begin
								if (ws_need > lmq_pkg::SUM_W'(lmq_pkg::AREA_BYTES)) begin
									st_q <= lmq_pkg::ST_FULL;
								end else begin
									hdr_q <= '0;
									state_q <= S_WS_HDR;
								end
							end
							lmq_pkg::KIND_WRITE_BYTE: begin
								if (wbl_q == '0) begin
									st_q <= lmq_pkg::ST_ERROR;
								end else begin
									pwp_q <= pwp_q + lmq_pkg::PW'(1);
									wbl_q <= wbl_q - lmq_pkg::LEN_W'(1);
									if (wbl_q == lmq_pkg::LEN_W'(1)) begin
										wp_q <= pwp_q + lmq_pkg::PW'(1);
										mw_q <= mw_q + 32'd1;
										last_q <= 1'b1;
										chk_q <= 1'b1;
									end
								end
							end
							lmq_pkg::KIND_READ_START: begin
								if (rbl_q != '0) st_q <= lmq_pkg::ST_ERROR;
								else if (rp_q >= wp_q) st_q <= lmq_pkg::ST_NO_MSG;
								else if (rs_hdr_end > lmq_pkg::SUM_W'(wp_q))
									st_q <= lmq_pkg::ST_ERROR;
								else state_q <= S_RS0;
							end
							lmq_pkg::KIND_READ_BYTE: begin
								if (rbl_q == '0) st_q <= lmq_pkg::ST_ERROR;
								else state_q <= S_RB0;
							end
							lmq_pkg::KIND_FLUSH: begin
								chk_q <= 1'b1;
							end
							lmq_pkg::KIND_REORG: begin
								base_q <= rp_q;
								src_q <= rp_q;
								end_q <= (wbl_q != '0) ? pwp_q : wp_q;
								v_s1 <= 1'b0;
								state_q <= S_REORG;
							end
							default: begin
								st_q <= lmq_pkg::ST_ERROR;
							end
						endcase
					end
				end
				S_WS_HDR: begin
					hdr_q <= hdr_q + lmq_pkg::HDR_W'(1);
					if (hdr_q == lmq_pkg::HDR_W'(lmq_pkg::HEADER_BYTES - 1)) begin
						pwp_q <= wp_q + lmq_pkg::PW'(lmq_pkg::HEADER_BYTES);
						wbl_q <= it_q.msg_length;
						if (it_q.msg_length == '0) begin
							wp_q <= wp_q + lmq_pkg::PW'(lmq_pkg::HEADER_BYTES);
							mw_q <= mw_q + 32'd1;
							last_q <= 1'b1;
							chk_q <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_RS0: state_q <= S_RS1;
				S_RS1: begin
					lo_q <= rdata_q;
					state_q <= S_RS2;
				end
				S_RS2: begin
					hl_q <= hl_c;
					if (lmq_pkg::HL_W'(it_q.capacity) < hl_c) begin
						st_q <= lmq_pkg::ST_TOO_SMALL;
						state_q <= S_DONE;
					end else if (rs_msg_end > lmq_pkg::SUM_W'(wp_q)) begin
						st_q <= lmq_pkg::ST_ERROR;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RS3;
					end
				end
				S_RS3: begin
					tlo_q <= rdata_q;
					state_q <= S_RS4;
				end
				S_RS4: begin
					otype_q <= {rdata_q, tlo_q};
					olen_q <= hl_q[lmq_pkg::LEN_W-1:0];
					rp_q <= rp_q + lmq_pkg::PW'(lmq_pkg::HEADER_BYTES);
					rbl_q <= hl_q[lmq_pkg::LEN_W-1:0];
					if (hl_q == '0) begin
						mr_q <= mr_q + 32'd1;
						last_q <= 1'b1;
						chk_q <= auto_flush;
					end
					state_q <= S_DONE;
				end
				S_RB0: state_q <= S_RB1;
				S_RB1: begin
					obyte_q <= rdata_q;
					rp_q <= rp_q + lmq_pkg::PW'(1);
					rbl_q <= rbl_q - lmq_pkg::LEN_W'(1);
					if (rbl_q == lmq_pkg::LEN_W'(1)) begin
						mr_q <= mr_q + 32'd1;
						last_q <= 1'b1;
						chk_q <= auto_flush;
					end
					state_q <= S_DONE;
				end
				S_REORG: begin
					// Read one byte ahead and write the one fetched last cycle.
					if (src_q < end_q) begin
						src_q <= src_q + lmq_pkg::PW'(1);
						addr_s1 <= src_q;
						v_s1 <= 1'b1;
					end else begin
						v_s1 <= 1'b0;
						if (!v_s1) begin
							wp_q <= (wp_q >= base_q) ? wp_q - base_q : '0;
							pwp_q <= (pwp_q >= base_q) ? pwp_q - base_q : '0;
							rp_q <= '0;
							chk_q <= 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// Empty check: the queue drained, so rewind every pointer.
					if (chk_q && rp_q >= wp_q && wbl_q == '0) begin
						rp_q <= '0;
						wp_q <= '0;
						pwp_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		result.status = st_q;
		result.out_type = otype_q;
		result.out_length = olen_q;
		result.out_byte = obyte_q;
		result.last_byte = last_q;
		result.written_count = mw_q;
		result.read_count = mr_q;
	end

endmodule

// File: rtl/linear_message_queue.sv
// Top level of the linear message queue: handshakes, register, result beat.
// Depends on lmq_pkg, lmq_core and linear_message_queue_defines.svh.

// A byte store of 4096 entries holding messages back to back, each as a
// 4-byte header (type, length) and its data. Every input beat gives exactly
// one result beat. Write_start makes one store write per header byte;
// read_start and read_byte go through the single read port with registered
// data; reorg moves one byte per cycle, reading one byte ahead and writing
// the byte fetched before it. No new beat is taken until the previous
// result beat has been delivered.
`include "linear_message_queue_defines.svh"

module linear_message_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [15:0] msg_type,
	input  logic [12:0] msg_length,
	input  logic [12:0] capacity,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] out_type,
	output logic [12:0] out_length,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic [31:0] written_count,
	output logic [31:0] read_count,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	lmq_pkg::item_t   item;
	lmq_pkg::result_t res, res_q;
	logic             core_idle, core_done, start;
	logic             out_valid_q, auto_flush_q;

	assign item = '{kind: kind, msg_type: msg_type, msg_length: msg_length,
		capacity: capacity, data_byte: data_byte};

	// An item enters only when the core is idle and the result slot is empty.
	assign in_stall = !core_idle || out_valid_q;
	assign start = in_valid && !in_stall;

	lmq_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.auto_flush (auto_flush_q),
		.idle       (core_idle),
		.done       (core_done),
		.result     (res)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_flush_q <= 1'b1;
		end else if (cfg_we) begin
			auto_flush_q <= cfg_wdata;
		end
	end

	// Result register toward the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (core_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign out_type = res_q.out_type;
	assign out_length = res_q.out_length;
	assign out_byte = res_q.out_byte;
	assign last_byte = res_q.last_byte;
	assign written_count = res_q.written_count;
	assign read_count = res_q.read_count;

	`LMQ_ASSERT(a_accept_empty, clk, arst_n, start |-> !out_valid, "beat taken with result pending")
	`LMQ_ASSERT(a_busy_after, clk, arst_n, start |=> in_stall, "second beat taken while busy")
	`LMQ_ASSERT(a_result_origin, clk, arst_n, $rose(out_valid) |-> $past(in_stall), "stray result")
	`LMQ_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

// File: sim/linear_message_queue_test.sv
// Self-checking testbench for linear_message_queue: directed and random beats.
// Depends on lmq_pkg and the linear_message_queue RTL; a scoreboard class predicts results.
`timescale 1ns / 1ps

module linear_message_queue_test;

	// Queue predictor and store of expected result beats.
	class queue_scoreboard;
		byte unsigned mem [lmq_pkg::AREA_BYTES];
		int unsigned wr_ptr, pend_ptr, wr_left, rd_ptr, rd_left;
		bit [31:0] n_written, n_read;
		bit flush_on;
		lmq_pkg::result_t pending [$];
		int errors;

		function new();
			foreach (mem[i]) mem[i] = 0;
			wr_ptr = 0; pend_ptr = 0; wr_left = 0; rd_ptr = 0; rd_left = 0;
			n_written = 0; n_read = 0; flush_on = 1'b1; errors = 0;
		endfunction

		function void empty_check();
			if (rd_ptr >= wr_ptr && wr_left == 0) begin
				rd_ptr = 0; wr_ptr = 0; pend_ptr = 0;
			end
		endfunction

		// Work out the result of one accepted input beat.
		function void note(logic [2:0] k, logic [15:0] t, logic [12:0] l,
				logic [12:0] c, logic [7:0] d);
			lmq_pkg::result_t r;
			int unsigned hl, base, stop;
			r = '0;
			r.status = lmq_pkg::ST_OK;
			case (k)
				lmq_pkg::KIND_WRITE_START: begin
					if (wr_ptr + lmq_pkg::HEADER_BYTES + l > lmq_pkg::AREA_BYTES) begin
						r.status = lmq_pkg::ST_FULL;
					end else begin
						mem[wr_ptr] = t[7:0];
						mem[wr_ptr + 1] = t[15:8];
						mem[wr_ptr + 2] = l[7:0];
						mem[wr_ptr + 3] = {3'b0, l[12:8]};
						pend_ptr = wr_ptr + lmq_pkg::HEADER_BYTES;
						wr_left = l;
						if (l == 0) begin
							wr_ptr = pend_ptr;
							n_written++;
							r.last_byte = 1'b1;
							empty_check();
						end
					end
				end
				lmq_pkg::KIND_WRITE_BYTE: begin
					if (wr_left == 0) begin
						r.status = lmq_pkg::ST_ERROR;
					end else begin
						if (pend_ptr < lmq_pkg::AREA_BYTES) mem[pend_ptr] = d;
						pend_ptr++;
						wr_left--;
						if (wr_left == 0) begin
							wr_ptr = pend_ptr;
							n_written++;
							r.last_byte = 1'b1;
							empty_check();
						end
					end
				end
				lmq_pkg::KIND_READ_START: begin
					if (rd_left != 0) r.status = lmq_pkg::ST_ERROR;
					else if (rd_ptr >= wr_ptr) r.status = lmq_pkg::ST_NO_MSG;
					else if (rd_ptr + lmq_pkg::HEADER_BYTES > wr_ptr)
						r.status = lmq_pkg::ST_ERROR;
					else begin
						hl = mem[rd_ptr + 2] | (mem[rd_ptr + 3] << 8);
						if (c < hl) r.status = lmq_pkg::ST_TOO_SMALL;
						else if (rd_ptr + lmq_pkg::HEADER_BYTES + hl > wr_ptr)
							r.status = lmq_pkg::ST_ERROR;
						else begin
							r.out_type = {mem[rd_ptr + 1], mem[rd_ptr]};
							r.out_length = 13'(hl);
							rd_ptr += lmq_pkg::HEADER_BYTES;
							rd_left = hl;
							if (hl == 0) begin
								n_read++;
								r.last_byte = 1'b1;
								if (flush_on) empty_check();
							end
						end
					end
				end
				lmq_pkg::KIND_READ_BYTE: begin
					if (rd_left == 0) begin
						r.status = lmq_pkg::ST_ERROR;
					end else begin
						r.out_byte = mem[rd_ptr];
						rd_ptr++;
						rd_left--;
						if (rd_left == 0) begin
							n_read++;
							r.last_byte = 1'b1;
							if (flush_on) empty_check();
						end
					end
				end
				lmq_pkg::KIND_FLUSH: empty_check();
				lmq_pkg::KIND_REORG: begin
					// Unread bytes and any partial message slide down to zero.
					base = rd_ptr;
					stop = (wr_left != 0) ? pend_ptr : wr_ptr;
					for (int unsigned i = base; i < stop; i++) mem[i - base] = mem[i];
					wr_ptr = (wr_ptr >= base) ? wr_ptr - base : 0;
					pend_ptr = (pend_ptr >= base) ? pend_ptr - base : 0;
					rd_ptr = 0;
					empty_check();
				end
				default: r.status = lmq_pkg::ST_ERROR;
			endcase
			r.written_count = n_written;
			r.read_count = n_read;
			pending.push_back(r);
		endfunction

		// Compare one result beat with the oldest expectation.
		function void check(lmq_pkg::result_t got);
			lmq_pkg::result_t exp_r;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result with no expectation: %p", $time, got);
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r) begin
				errors++;
				$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [2:0] kind;
	logic [15:0] msg_type;
	logic [12:0] msg_length, capacity;
	logic [7:0] data_byte;
	logic [2:0] status;
	logic [15:0] out_type;
	logic [12:0] out_length;
	logic [7:0] out_byte;
	logic last_byte;
	logic [31:0] written_count, read_count;
	logic cfg_we, cfg_wdata;

	queue_scoreboard board;
	int beats_in;
	int hold_cycles;
	bit idle_on;

	linear_message_queue dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .msg_type(msg_type), .msg_length(msg_length),
		.capacity(capacity), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_type(out_type), .out_length(out_length),
		.out_byte(out_byte), .last_byte(last_byte),
		.written_count(written_count), .read_count(read_count),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Sample both channels at the rising edge.
	always @(posedge clk) begin
		lmq_pkg::result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note(kind, msg_type, msg_length, capacity, data_byte);
				beats_in++;
			end
			if (out_valid && !out_stall) begin
				got.status = lmq_pkg::status_t'(status);
				got.out_type = out_type;
				got.out_length = out_length;
				got.out_byte = out_byte;
				got.last_byte = last_byte;
				got.written_count = written_count;
				got.read_count = read_count;
				board.check(got);
			end
		end
	end

	// Receiver: random stalls, plus a counted hold-off when asked.
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall = 1;
			end else begin
				out_stall = idle_on && ($urandom_range(0, 99) < 13);
			end
		end
	end

	// Offer one input beat and wait until it is taken.
	task automatic send(int unsigned k, int unsigned t, int unsigned l,
			int unsigned c, int unsigned d);
		int seen;
		while (idle_on && $urandom_range(0, 99) < 13) begin
			in_valid = 0;
			@(negedge clk);
		end
		kind = 3'(k); msg_type = 16'(t); msg_length = 13'(l); capacity = 13'(c);
		data_byte = 8'(d);
		in_valid = 1;
		seen = beats_in;
		do @(negedge clk); while (beats_in == seen);
	endtask

	task automatic drain();
		in_valid = 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic set_flush(bit v);
		drain();
		cfg_we = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 0;
		board.flush_on = v;
	endtask

	task automatic put_message(int len, bit cut);
		send(lmq_pkg::KIND_WRITE_START, $urandom, len, $urandom, $urandom);
		for (int i = 0; i < len; i++) begin
			if (cut && $urandom_range(0, 3) == 0) break;
			send(lmq_pkg::KIND_WRITE_BYTE, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic get_message();
		logic [12:0] cap;
		cap = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 20))
			: 13'(13'h1fff - $urandom_range(0, 4000));
		send(lmq_pkg::KIND_READ_START, $urandom, $urandom, cap, $urandom);
		while (board.rd_left > 0) begin
			if ($urandom_range(0, 60) == 0) break;
			send(lmq_pkg::KIND_READ_BYTE, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic random_phase(int count);
		int start, pick, len;
		start = beats_in;
		while (beats_in - start < count) begin
			pick = $urandom_range(0, 99);
			len = ($urandom_range(0, 40) == 0) ? $urandom_range(0, 600) : $urandom_range(0, 12);
			if (pick < 40) put_message(len, $urandom_range(0, 19) == 0);
			else if (pick < 82) get_message();
			else if (pick < 86)
				send(lmq_pkg::KIND_REORG, $urandom, $urandom, $urandom, $urandom);
			else if (pick < 89)
				send(lmq_pkg::KIND_FLUSH, $urandom, $urandom, $urandom, $urandom);
			else send($urandom, $urandom, $urandom, $urandom, $urandom);
			if ($urandom_range(0, 150) == 0) idle_on = !idle_on;
		end
	endtask

	initial begin
		board = new();
		beats_in = 0;
		hold_cycles = 0;
		idle_on = 0;
		arst_n = 0;
		in_valid = 0; kind = 0; msg_type = 0; msg_length = 0; capacity = 0;
		data_byte = 0; cfg_we = 0; cfg_wdata = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes and each special case.
		set_flush(1);
		send(lmq_pkg::KIND_READ_START, 0, 0, 0, 0);
		send(lmq_pkg::KIND_WRITE_START, 16'hffff, 0, 0, 0);
		send(lmq_pkg::KIND_READ_START, 0, 0, 0, 0);
		send(lmq_pkg::KIND_WRITE_START, 16'h1234, 3, 0, 0);
		send(lmq_pkg::KIND_WRITE_BYTE, 0, 0, 0, 8'hff);
		send(lmq_pkg::KIND_FLUSH, 0, 0, 0, 0);
		send(lmq_pkg::KIND_WRITE_BYTE, 0, 0, 0, 8'h00);
		send(lmq_pkg::KIND_WRITE_BYTE, 0, 0, 0, 8'ha5);
		send(lmq_pkg::KIND_WRITE_BYTE, 0, 0, 0, 8'h5a);
		send(lmq_pkg::KIND_READ_START, 0, 0, 2, 0);
		send(lmq_pkg::KIND_READ_START, 0, 0, 13'h1fff, 0);
		send(lmq_pkg::KIND_READ_START, 0, 0, 13'h1fff, 0);
		send(lmq_pkg::KIND_READ_BYTE, 0, 0, 0, 0);
		send(lmq_pkg::KIND_READ_BYTE, 0, 0, 0, 0);
		send(lmq_pkg::KIND_READ_BYTE, 0, 0, 0, 0);
		send(lmq_pkg::KIND_READ_BYTE, 0, 0, 0, 0);
		send(lmq_pkg::KIND_WRITE_START, 0, 13'h1fff, 0, 0);
		send(lmq_pkg::KIND_WRITE_START, 16'h00ff, 4092, 0, 0);
		send(lmq_pkg::KIND_WRITE_START, 16'hff00, 1, 0, 0);
		send(lmq_pkg::KIND_WRITE_BYTE, 0, 0, 0, 8'h81);
		send(3'd6, 16'hffff, 13'h1fff, 13'h1fff, 8'hff);
		send(3'd7, 0, 0, 0, 0);
		send(lmq_pkg::KIND_REORG, 0, 0, 0, 0);
		send(lmq_pkg::KIND_READ_START, 0, 0, 4096, 0);
		send(lmq_pkg::KIND_READ_BYTE, 0, 0, 0, 0);

		// Random phases across both register settings.
		set_flush(0);
		idle_on = 1;
		random_phase(500);
		hold_cycles = 400;
		random_phase(100);
		set_flush(1);
		random_phase(600);
		set_flush(0);
		idle_on = 0;
		random_phase(250);
		idle_on = 1;
		set_flush(1);
		random_phase(500);

		drain();
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
